// ----- sv/llpr_pkg.sv -----
// ----------------------------------------------------------------------------
// llpr_pkg
// Types and constants shared by the lidar label projection raster.
// ----------------------------------------------------------------------------
package llpr_pkg;

	// Field widths settled by the request and result formats.
	localparam int ROW_W  = 11;   // row of a raster pixel, up to 2048 rows
	localparam int COL_W  = 12;   // column of a raster pixel, up to 4096 columns
	localparam int WID_W  = 13;   // active width, up to 4096
	localparam int HGT_W  = 12;   // active height, up to 2048
	localparam int PROD_W = 36;   // Q1.14 coefficient times point coordinate
	localparam int CORD_W = 38;   // camera coordinate in 1/(1024*16384) m
	localparam int NUM_W  = 56;   // projection numerator
	localparam int DIV_W  = 58;   // divider remainder
	localparam int Q_W    = 13;   // quotient bits that can land inside the image
	localparam int QUO_W  = Q_W + 1;
	localparam int CNT_W  = 4;
	localparam int CFG_IDX_W = 3;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;

	localparam logic signed [CORD_W-1:0] NEAR_LIMIT = 38'sd8388608;

	localparam logic [63:0] KEPT_RESET   = 64'd20266456024350760;
	localparam logic [11:0] WIDTH_RESET  = 12'd1242;
	localparam logic [9:0]  HEIGHT_RESET = 10'd375;

	localparam logic [1:0] REQ_PROJECT = 2'd0;
	localparam logic [1:0] REQ_READ    = 2'd1;
	localparam logic [1:0] REQ_CLEAR   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INTR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEPT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd6;

	typedef enum logic [2:0] {
		ST_WRITTEN   = 3'd0,
		ST_CLASS_REJ = 3'd1,
		ST_TOO_NEAR  = 3'd2,
		ST_OFF_IMAGE = 3'd3,
		ST_READ_DONE = 3'd4,
		ST_CLEARED   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OP_REPORT = 2'd0,
		OP_WRITE  = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		status_t          status;
		logic [15:0]      label;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} cmd_t;

	typedef struct packed {
		logic [63:0]      row_x;
		logic [63:0]      row_y;
		logic [63:0]      row_z;
		logic [63:0]      intr;
		logic [63:0]      kept;
		logic [WID_W-1:0] width;
		logic [HGT_W-1:0] height;
	} cfg_t;

	typedef enum logic [3:0] {
		F_IDLE, F_MUL, F_SUM, F_CHK, F_PMUL, F_PSUM, F_PREP, F_DIV, F_FIN, F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_INIT, B_IDLE, B_DIL, B_FIN
	} back_state_t;

endpackage

// ----- sv/llpr_req_if.sv -----
// ----------------------------------------------------------------------------
// llpr_req_if
// Request channel: project a point, read a dilated pixel or clear a pixel.
// ----------------------------------------------------------------------------
interface llpr_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [19:0] point_x;
	logic signed [19:0] point_y;
	logic signed [19:0] point_z;
	logic [15:0]        point_class;
	logic [8:0]         pixel_row;
	logic [10:0]        pixel_col;

	modport source(output valid, req_type, point_x, point_y, point_z, point_class,
		pixel_row, pixel_col, input ready);
	modport sink(input valid, req_type, point_x, point_y, point_z, point_class,
		pixel_row, pixel_col, output ready);
endinterface

// ----- sv/llpr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// llpr_rsp_if
// Result channel: one result for every request except those of code 3.
// ----------------------------------------------------------------------------
interface llpr_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] label_out;
	logic [8:0]  out_row;
	logic [10:0] out_col;

	modport source(output valid, status, label_out, out_row, out_col, input ready);
	modport sink(input valid, status, label_out, out_row, out_col, output ready);
endinterface

// ----- sv/llpr_cfg_if.sv -----
// ----------------------------------------------------------------------------
// llpr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface llpr_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/lidar_label_projection_raster.sv -----
// ----------------------------------------------------------------------------
// lidar_label_projection_raster
// Projects labelled lidar points into a camera label raster and serves
// dilated reads and single-pixel clears.
// ----------------------------------------------------------------------------
// Requests enter on req_ch, one result per request leaves on rsp_ch (code 3
// requests give none), and cfg_ch writes the seven registers, which the user
// must do only while idle; the block itself does not enforce this. A
// projection passes a multiply stage for the rigid transform, a second for
// the pinhole numerators, and a restoring divider that produces one quotient
// bit per cycle. Rejected, read and clear requests go from accept straight to
// the push state, and too-near points leave after the near check. In the back
// a write or clear is done as it is popped, and a dilated read makes up to
// 2*DILATE_RADIUS+1 reads on the single raster read port.
// After reset the raster's MAX_WIDTH*MAX_HEIGHT entries are zeroed one entry
// per cycle, during which req_ch.ready stays low; cfg_ch is always ready.
// When the receiver stalls, the result register holds, a four-entry command
// queue fills, and then the front holds its finished request until space frees.
// ----------------------------------------------------------------------------
module lidar_label_projection_raster import llpr_pkg::*; #(
	parameter int MAX_WIDTH     = 2048,
	parameter int MAX_HEIGHT    = 512,
	parameter int DILATE_RADIUS = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	llpr_req_if.sink   req_ch,
	llpr_rsp_if.source rsp_ch,
	llpr_cfg_if.sink   cfg_ch
);

	logic [63:0] row_x_q, row_y_q, row_z_q, intr_q, kept_q;
	logic [11:0] width_q;
	logic [9:0]  height_q;
	cfg_t        cfg;
	cmd_t        f_cmd, q_cmd;
	logic        f_valid, f_ready, q_valid, q_ready, init_done;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q  <= '0;
			row_y_q  <= '0;
			row_z_q  <= '0;
			intr_q   <= '0;
			kept_q   <= KEPT_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				CFG_ROW_X:  row_x_q  <= cfg_ch.data;
				CFG_ROW_Y:  row_y_q  <= cfg_ch.data;
				CFG_ROW_Z:  row_z_q  <= cfg_ch.data;
				CFG_INTR:   intr_q   <= cfg_ch.data;
				CFG_KEPT:   kept_q   <= cfg_ch.data;
				CFG_WIDTH:  width_q  <= cfg_ch.data[11:0];
				CFG_HEIGHT: height_q <= cfg_ch.data[9:0];
				default: begin
				end
			endcase
		end
	end

	// Sizes beyond the raster act as the raster's own size.
	always_comb begin
		cfg.row_x  = row_x_q;
		cfg.row_y  = row_y_q;
		cfg.row_z  = row_z_q;
		cfg.intr   = intr_q;
		cfg.kept   = kept_q;
		cfg.width  = (WID_W'(width_q) > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH)
			: WID_W'(width_q);
		cfg.height = (HGT_W'(height_q) > HGT_W'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT)
			: HGT_W'(height_q);
	end

	llpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (init_done),
		.cfg       (cfg),
		.req       (req_ch),
		.cmd       (f_cmd),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready)
	);

	llpr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (f_cmd),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_cmd    (q_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready)
	);

	llpr_back #(
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_HEIGHT    (MAX_HEIGHT),
		.DILATE_RADIUS (DILATE_RADIUS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.width     (cfg.width),
		.cmd       (q_cmd),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.init_done (init_done),
		.rsp       (rsp_ch)
	);

endmodule

// ----- sv/llpr_front.sv -----
// ----------------------------------------------------------------------------
// llpr_front
// Accepts requests, filters classes, transforms and projects points, and
// hands one raster command per request, none for code 3, to the queue.
// ----------------------------------------------------------------------------
module llpr_front import llpr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  cfg_t       cfg,
	llpr_req_if.sink   req,
	output cmd_t       cmd,
	output logic       cmd_valid,
	input  logic       cmd_ready
);

	front_state_t state_q, state_d;

	logic signed [19:0]        pt_q [3];
	logic [15:0]               cls_q;
	logic signed [PROD_W-1:0]  prod_q [3][3];
	logic signed [CORD_W-1:0]  cam_q [3];
	logic signed [NUM_W-1:0]   pa_q [2];
	logic signed [NUM_W-1:0]   pb_q [2];
	logic signed [NUM_W-1:0]   num_q [2];
	logic                      neg_q [2];
	logic [DIV_W-1:0]          rem_q [2];
	logic [QUO_W-1:0]          quo_q [2];
	logic [DIV_W-1:0]          dsh_q;
	logic [CNT_W-1:0]          cnt_q;
	cmd_t                      cmd_q;

	logic        acc;
	logic        kept;
	cmd_t        acc_cmd;
	cmd_t        fin_cmd;
	logic [63:0] trow [3];
	logic [NUM_W-1:0] mag [2];
	logic        ge [2];
	logic        off_x, off_y;
	logic [CORD_W-1:0] zc_u;

	assign trow[0] = cfg.row_x;
	assign trow[1] = cfg.row_y;
	assign trow[2] = cfg.row_z;
	assign zc_u    = $unsigned(cam_q[2]);

	assign acc = req.valid && req.ready;

	// Classification of a request at the moment it is taken.
	always_comb begin
		kept = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (cfg.kept[16*i +: 16] == req.point_class)
				kept = 1'b1;
		end
		acc_cmd = '{op: OP_REPORT, status: ST_CLASS_REJ, label: 16'd0,
			row: ROW_W'(req.pixel_row), col: COL_W'(req.pixel_col)};
		case (req.req_type)
			REQ_READ: begin
				acc_cmd.status = ST_READ_DONE;
				if (HGT_W'(req.pixel_row) < cfg.height && WID_W'(req.pixel_col) < cfg.width)
					acc_cmd.op = OP_READ;
			end
			REQ_CLEAR: begin
				acc_cmd.status = ST_CLEARED;
				if (HGT_W'(req.pixel_row) < cfg.height && WID_W'(req.pixel_col) < cfg.width)
					acc_cmd.op = OP_CLEAR;
			end
			default: begin
				acc_cmd.row = '0;
				acc_cmd.col = '0;
			end
		endcase
	end

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			mag[a] = num_q[a][NUM_W-1] ? $unsigned(-num_q[a]) : $unsigned(num_q[a]);
			ge[a]  = rem_q[a] >= dsh_q;
		end
		// A negative numerator only lands on the image when it rounds to zero.
		off_x = (neg_q[0] && quo_q[0] != '0) || quo_q[0] >= QUO_W'(cfg.width);
		off_y = (neg_q[1] && quo_q[1] != '0) || quo_q[1] >= QUO_W'(cfg.height);
		if (off_x || off_y)
			fin_cmd = '{op: OP_REPORT, status: ST_OFF_IMAGE, label: 16'd0, row: '0, col: '0};
		else
			fin_cmd = '{op: OP_WRITE, status: ST_WRITTEN, label: cls_q,
				row: quo_q[1][ROW_W-1:0], col: quo_q[0][COL_W-1:0]};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (acc) begin
					case (req.req_type)
						REQ_PROJECT: state_d = kept ? F_MUL : F_PUSH;
						REQ_READ:    state_d = F_PUSH;
						REQ_CLEAR:   state_d = F_PUSH;
						default:     state_d = F_IDLE;
					endcase
				end
			end
			F_MUL:  state_d = F_SUM;
			F_SUM:  state_d = F_CHK;
			F_CHK:  state_d = (cam_q[2] <= NEAR_LIMIT) ? F_PUSH : F_PMUL;
			F_PMUL: state_d = F_PSUM;
			F_PSUM: state_d = F_PREP;
			F_PREP: state_d = F_DIV;
			F_DIV:  state_d = (cnt_q == CNT_W'(Q_W)) ? F_FIN : F_DIV;
			F_FIN:  state_d = F_PUSH;
			F_PUSH: state_d = cmd_ready ? F_IDLE : F_PUSH;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == F_IDLE) && en;
		cmd_valid = (state_q == F_PUSH);
		cmd       = cmd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (acc) begin
					pt_q[0] <= req.point_x;
					pt_q[1] <= req.point_y;
					pt_q[2] <= req.point_z;
					cls_q   <= req.point_class;
					cmd_q   <= acc_cmd;
				end
			end
			F_MUL: begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						prod_q[i][j] <= $signed(trow[i][16*j +: 16]) * pt_q[j];
			end
			F_SUM: begin
				for (int i = 0; i < 3; i++)
					cam_q[i] <= CORD_W'(prod_q[i][0]) + CORD_W'(prod_q[i][1]) +
						CORD_W'(prod_q[i][2]) + (CORD_W'($signed(trow[i][63:48])) <<< 14);
			end
			F_CHK: begin
				cmd_q <= '{op: OP_REPORT, status: ST_TOO_NEAR, label: 16'd0, row: '0, col: '0};
			end
			F_PMUL: begin
				pa_q[0] <= $signed({1'b0, cfg.intr[15:0]}) * cam_q[0];
				pb_q[0] <= $signed({1'b0, cfg.intr[47:32]}) * cam_q[2];
				pa_q[1] <= $signed({1'b0, cfg.intr[31:16]}) * cam_q[1];
				pb_q[1] <= $signed({1'b0, cfg.intr[63:48]}) * cam_q[2];
			end
			F_PSUM: begin
				num_q[0] <= pa_q[0] + pb_q[0];
				num_q[1] <= pa_q[1] + pb_q[1];
			end
			F_PREP: begin
				// Rounding half away from zero: (2|num| + 16z) / (32z).
				for (int a = 0; a < 2; a++) begin
					neg_q[a] <= num_q[a][NUM_W-1];
					rem_q[a] <= (DIV_W'(mag[a]) << 1) + (DIV_W'(zc_u) << 4);
					quo_q[a] <= '0;
				end
				dsh_q <= DIV_W'(zc_u) << (5 + Q_W);
				cnt_q <= '0;
			end
			F_DIV: begin
				for (int a = 0; a < 2; a++) begin
					if (ge[a])
						rem_q[a] <= rem_q[a] - dsh_q;
					quo_q[a] <= {quo_q[a][QUO_W-2:0], ge[a]};
				end
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			F_FIN: begin
				cmd_q <= fin_cmd;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- sv/llpr_queue.sv -----
// ----------------------------------------------------------------------------
// llpr_queue
// Short command queue between the front and the raster back end.
// ----------------------------------------------------------------------------
module llpr_queue import llpr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t push_cmd,
	input  logic push_valid,
	output logic push_ready,
	output cmd_t pop_cmd,
	output logic pop_valid,
	input  logic pop_ready
);

	cmd_t               buf_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [Q_PTR_W:0]   cnt_q;
	logic               do_push, do_pop;

	assign push_ready = cnt_q != (Q_PTR_W+1)'(Q_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_cmd    = buf_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + Q_PTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + Q_PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + (Q_PTR_W+1)'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - (Q_PTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			buf_q[wr_q] <= push_cmd;
	end

endmodule

// ----- sv/llpr_back.sv -----
// ----------------------------------------------------------------------------
// llpr_back
// Label raster memory: clearing pass, writes, clears, dilated reads and the
// result register.
// ----------------------------------------------------------------------------
module llpr_back import llpr_pkg::*; #(
	parameter int MAX_WIDTH     = 2048,
	parameter int MAX_HEIGHT    = 512,
	parameter int DILATE_RADIUS = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [WID_W-1:0] width,
	input  cmd_t       cmd,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	output logic       init_done,
	llpr_rsp_if.source rsp
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int NTAP  = 2 * DILATE_RADIUS + 1;
	localparam int KW    = $clog2(NTAP + 1);
	localparam int NXW   = COL_W + 2;

	back_state_t state_q, state_d;

	logic [15:0]   mem_q [DEPTH];
	logic [15:0]   rdata_q;
	logic [AW-1:0] clr_q;
	logic [KW-1:0] k_q;
	logic          pend_q;
	cmd_t          cur_q;
	logic [15:0]   lab_q;
	logic          ovld_q;
	status_t       ost_q;
	logic [15:0]   olab_q;
	logic [8:0]    orow_q;
	logic [10:0]   ocol_q;

	logic          out_free, pop, load, hit, dil_done, nx_ok;
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [15:0]   wdata;
	logic [NXW-1:0] nx;
	cmd_t          ld;

	function automatic logic [AW-1:0] addr_of(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		return AW'(r[RW-1:0]) * AW'(MAX_WIDTH) + AW'(c[CW-1:0]);
	endfunction

	assign out_free  = !ovld_q || rsp.ready;
	assign init_done = state_q != B_INIT;

	// Taps run from the rightmost column leftward; the first nonzero one wins.
	assign nx       = NXW'(cur_q.col) + NXW'(DILATE_RADIUS) - NXW'(k_q);
	assign nx_ok    = !nx[NXW-1] && nx < NXW'(width);
	assign hit      = pend_q && rdata_q != 16'd0;
	assign dil_done = hit || k_q == KW'(NTAP);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_INIT: if (clr_q == AW'(DEPTH - 1)) state_d = B_IDLE;
			B_IDLE: if (pop && cmd.op == OP_READ) state_d = B_DIL;
			B_DIL:  if (dil_done) state_d = B_FIN;
			B_FIN:  if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop   = 1'b0;
		load  = 1'b0;
		we    = 1'b0;
		waddr = addr_of(cmd.row, cmd.col);
		wdata = 16'd0;
		re    = 1'b0;
		raddr = addr_of(cur_q.row, nx[COL_W-1:0]);
		ld    = cmd;
		case (state_q)
			B_INIT: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			B_IDLE: begin
				pop  = cmd_valid && out_free;
				load = pop && cmd.op != OP_READ;
				we   = pop && (cmd.op == OP_WRITE || cmd.op == OP_CLEAR);
				if (cmd.op == OP_WRITE)
					wdata = cmd.label;
			end
			B_DIL: begin
				re = !dil_done && nx_ok;
			end
			B_FIN: begin
				load     = out_free;
				ld       = cur_q;
				ld.label = lab_q;
			end
			default: begin
			end
		endcase
		cmd_ready = pop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			clr_q   <= '0;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_INIT)
				clr_q <= clr_q + AW'(1);
			if (load)
				ovld_q <= 1'b1;
			else if (rsp.ready)
				ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk) begin
		if (pop && cmd.op == OP_READ) begin
			cur_q  <= cmd;
			k_q    <= '0;
			pend_q <= 1'b0;
		end
		if (state_q == B_DIL) begin
			if (dil_done)
				lab_q <= hit ? rdata_q : 16'd0;
			else begin
				k_q    <= k_q + KW'(1);
				pend_q <= nx_ok;
			end
		end
		if (load) begin
			ost_q  <= ld.status;
			olab_q <= ld.label;
			orow_q <= ld.row[8:0];
			ocol_q <= ld.col[10:0];
		end
	end

	assign rsp.valid     = ovld_q;
	assign rsp.status    = ost_q;
	assign rsp.label_out = olab_q;
	assign rsp.out_row   = orow_q;
	assign rsp.out_col   = ocol_q;

endmodule
